// ===== rtl/bctl_pkg.sv =====
package bctl_pkg;

  localparam int unsigned MAX_TILE_DIM   = 1024;
  localparam int unsigned MAX_GRID_DIM   = 64;
  localparam int unsigned MAX_TILE_ELEMS = 65536;

  localparam int unsigned COORD_W    = 10;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned GRID_W     = 7;
  localparam int unsigned GPOS_W     = 6;
  localparam int unsigned RANK_W     = 12;
  localparam int unsigned ELEMS_W    = 17;
  localparam int unsigned IDX_W      = 20;
  localparam int unsigned OFF_W      = 36;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned DIV_STEPS  = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_TILE_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUPER_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUPER_COLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MY_RANK    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_ELEMS = 3'd7;

  // partial remainder and shifting dividend/quotient of a restoring divider
  typedef struct packed {
    logic [DIM_W-1:0] rem;
    logic [DIM_W-1:0] quo;
  } div_t;

  function automatic div_t div_step(div_t d, logic [DIM_W-1:0] dvs);
    logic [DIM_W:0] t;
    div_t r;
    t = {d.rem, d.quo[DIM_W-1]};
    if (t >= {1'b0, dvs}) begin
      r.rem = DIM_W'(t - {1'b0, dvs});
      r.quo = {d.quo[DIM_W-2:0], 1'b1};
    end else begin
      r.rem = t[DIM_W-1:0];
      r.quo = {d.quo[DIM_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_W'(MAX_TILE_DIM)) return DIM_W'(MAX_TILE_DIM);
    return v;
  endfunction

  function automatic logic [GRID_W-1:0] clamp_grid(logic [GRID_W-1:0] v);
    if (v == '0) return GRID_W'(1);
    if (v > GRID_W'(MAX_GRID_DIM)) return GRID_W'(MAX_GRID_DIM);
    return v;
  endfunction

  function automatic logic [ELEMS_W-1:0] clamp_elems(logic [ELEMS_W-1:0] v);
    if (v == '0) return ELEMS_W'(1);
    if (v > ELEMS_W'(MAX_TILE_ELEMS)) return ELEMS_W'(MAX_TILE_ELEMS);
    return v;
  endfunction

endpackage

// ===== rtl/bctl_if.sv =====
interface bctl_req_if import bctl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] tile_row;
  logic [COORD_W-1:0] tile_col;

  modport source (output valid, tile_row, tile_col, input ready);
  modport sink (input valid, tile_row, tile_col, output ready);
endinterface

interface bctl_loc_if import bctl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] owner_rank;
  logic [GPOS_W-1:0] owner_grid_row;
  logic [GPOS_W-1:0] owner_grid_col;
  logic              is_local;
  logic [IDX_W-1:0]  local_tile_index;
  logic [OFF_W-1:0]  element_offset;
  logic              out_of_range;

  modport source (output valid, owner_rank, owner_grid_row, owner_grid_col, is_local,
                  local_tile_index, element_offset, out_of_range, input ready);
  modport sink (input valid, owner_rank, owner_grid_row, owner_grid_col, is_local,
                local_tile_index, element_offset, out_of_range, output ready);
endinterface

// ===== rtl/block_cyclic_tile_locator.sv =====
// Tile locator for a 2D block-cyclic matrix layout with super-tiles.
// req_i takes one item (tile_row, tile_col) per valid/ready handshake; loc_o
// returns one item per request: owner rank and grid position, is_local, the
// local tile index, its element offset and an out-of-range flag.
// In the pipeline, 11 stages divide the coordinate by the super-tile size,
// 11 more divide the super-tile index by the grid size (one quotient bit
// per stage), then 6 stages of multiply/add build the local offset.
// One item per cycle unless loc_o stalls or the config is re-derived. A
// stall on loc_o freezes the whole pipeline and drops req_i.ready; nothing
// is lost or repeated. Config is written via cfg_we_i/cfg_idx_i/cfg_data_i
// while the block is empty; the user must keep to this, the block does not
// enforce it. After each write a shared divider re-derives the super-tile
// counts, and req_i.ready stays low until it is done. Reset sets every
// dimension to 1, my_rank to 0, tile_elems to 1, and empties the pipeline.
module block_cyclic_tile_locator import bctl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bctl_req_if.sink              req_i,
  bctl_loc_if.source            loc_o
);

  localparam int unsigned L = DIV_STEPS - 1;

  localparam logic [1:0] CS_IDLE = 2'd0;
  localparam logic [1:0] CS_ROWS = 2'd1;
  localparam logic [1:0] CS_COLS = 2'd2;
  localparam logic [1:0] CS_NSUP = 2'd3;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [GPOS_W-1:0] grow;
    logic [GPOS_W-1:0] gcol;
    logic              loc;
    logic              oor;
  } own_t;

  // configuration
  logic [DIM_W-1:0]   trows_q, tcols_q, srows_q, scols_q;
  logic [GRID_W-1:0]  grows_q, gcols_q;
  logic [RANK_W-1:0]  my_rank_q;
  logic [ELEMS_W-1:0] elems_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trows_q   <= DIM_W'(1);
      tcols_q   <= DIM_W'(1);
      srows_q   <= DIM_W'(1);
      scols_q   <= DIM_W'(1);
      grows_q   <= GRID_W'(1);
      gcols_q   <= GRID_W'(1);
      my_rank_q <= '0;
      elems_q   <= ELEMS_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TILE_ROWS:  trows_q   <= clamp_dim(cfg_data_i[DIM_W-1:0]);
        REG_TILE_COLS:  tcols_q   <= clamp_dim(cfg_data_i[DIM_W-1:0]);
        REG_SUPER_ROWS: srows_q   <= clamp_dim(cfg_data_i[DIM_W-1:0]);
        REG_SUPER_COLS: scols_q   <= clamp_dim(cfg_data_i[DIM_W-1:0]);
        REG_GRID_ROWS:  grows_q   <= clamp_grid(cfg_data_i[GRID_W-1:0]);
        REG_GRID_COLS:  gcols_q   <= clamp_grid(cfg_data_i[GRID_W-1:0]);
        REG_MY_RANK:    my_rank_q <= cfg_data_i[RANK_W-1:0];
        REG_TILE_ELEMS: elems_q   <= clamp_elems(cfg_data_i);
        default: ;
      endcase
    end
  end

  // derived config: T/s, C/c and (super-tile rows - 1)/grid_rows
  logic [1:0]        state_q;
  logic [3:0]        cnt_q;
  div_t              sd_q, sstep;
  logic [DIM_W-1:0]  sdvs, sdivd, nsm1;
  logic [DIM_W-1:0]  tq_q, tr_q, cq_q, cr_q, nsq_q;
  logic [GPOS_W-1:0] nsr_q;

  assign nsm1 = DIM_W'(tq_q + {{(DIM_W-1){1'b0}}, |tr_q} - DIM_W'(1));

  always_comb begin
    unique case (state_q)
      CS_COLS: begin
        sdvs  = scols_q;
        sdivd = tcols_q;
      end
      CS_NSUP: begin
        sdvs  = DIM_W'(grows_q);
        sdivd = nsm1;
      end
      default: begin
        sdvs  = srows_q;
        sdivd = trows_q;
      end
    endcase
    sstep = div_step(sd_q, sdvs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      cnt_q   <= '0;
      sd_q    <= '0;
      tq_q    <= DIM_W'(1);
      tr_q    <= '0;
      cq_q    <= DIM_W'(1);
      cr_q    <= '0;
      nsq_q   <= '0;
      nsr_q   <= '0;
    end else if (cfg_we_i) begin
      state_q <= CS_ROWS;
      cnt_q   <= '0;
    end else if (state_q != CS_IDLE) begin
      if (cnt_q == '0) begin
        sd_q  <= '{rem: '0, quo: sdivd};
        cnt_q <= 4'd1;
      end else begin
        sd_q <= sstep;
        if (cnt_q == 4'(DIV_STEPS)) begin
          cnt_q <= '0;
          unique case (state_q)
            CS_ROWS: begin
              tq_q    <= sstep.quo;
              tr_q    <= sstep.rem;
              state_q <= CS_COLS;
            end
            CS_COLS: begin
              cq_q    <= sstep.quo;
              cr_q    <= sstep.rem;
              state_q <= CS_NSUP;
            end
            default: begin
              nsq_q   <= sstep.quo;
              nsr_q   <= sstep.rem[GPOS_W-1:0];
              state_q <= CS_IDLE;
            end
          endcase
        end else begin
          cnt_q <= cnt_q + 4'd1;
        end
      end
    end
  end

  // pipeline control: whole pipe advances together
  logic en, acc;
  assign en          = !loc_o.valid || loc_o.ready;
  assign req_i.ready = en && (state_q == CS_IDLE);
  assign acc         = req_i.valid && req_i.ready;

  // stage A: m / super_rows, n / super_cols
  logic [DIV_STEPS-1:0] a_v_q;
  div_t                 a_m_q [DIV_STEPS];
  div_t                 a_n_q [DIV_STEPS];
  logic                 a_oor_q [DIV_STEPS];

  // stage B: super-tile index / grid size
  logic [DIV_STEPS-1:0] b_v_q;
  div_t                 b_r_q [DIV_STEPS];
  div_t                 b_c_q [DIV_STEPS];
  logic [COORD_W-1:0]   b_mrem_q [DIV_STEPS];
  logic [COORD_W-1:0]   b_nrem_q [DIV_STEPS];
  logic                 b_oor_q [DIV_STEPS];
  logic                 b_hsel_q [DIV_STEPS];
  logic                 b_wsel_q [DIV_STEPS];

  div_t a_m_in, a_n_in, b_r_in, b_c_in;
  logic a_oor_in;
  assign a_m_in   = '{rem: '0, quo: {1'b0, req_i.tile_row}};
  assign a_n_in   = '{rem: '0, quo: {1'b0, req_i.tile_col}};
  assign a_oor_in = ({1'b0, req_i.tile_row} >= trows_q) ||
                    ({1'b0, req_i.tile_col} >= tcols_q);
  assign b_r_in   = '{rem: '0, quo: a_m_q[L].quo};
  assign b_c_in   = '{rem: '0, quo: a_n_q[L].quo};

  // post-divide terms
  logic [GPOS_W-1:0] rr, cr;
  logic [COORD_W-1:0] qr, qc;
  logic [RANK_W:0]    rank_full;
  logic [DIM_W-1:0]   nown;
  assign rr        = b_r_q[L].rem[GPOS_W-1:0];
  assign cr        = b_c_q[L].rem[GPOS_W-1:0];
  assign qr        = b_r_q[L].quo[COORD_W-1:0];
  assign qc        = b_c_q[L].quo[COORD_W-1:0];
  assign rank_full = {{(RANK_W+1-GPOS_W){1'b0}}, rr} * {{(RANK_W+1-GRID_W){1'b0}}, gcols_q}
                   + {{(RANK_W+1-GPOS_W){1'b0}}, cr};
  assign nown      = (rr <= nsr_q) ? DIM_W'(nsq_q + DIM_W'(1)) : nsq_q;

  logic [5:0]           p_v_q;
  own_t                 p1_o_q, p2_o_q, p3_o_q, p4_o_q, p5_o_q, p6_o_q;
  logic [2*DIM_W-1:0]   p1_ownm_q;
  logic [DIM_W-1:0]     p1_dsub_q, p1_wid_q, p1_hgt_q;
  logic [COORD_W-1:0]   p1_qr_q, p1_qc_q, p1_mrem_q, p1_nrem_q;
  logic [DIM_W-1:0]     p2_owned_q;
  logic [2*DIM_W-1:0]   p2_wh_q;
  logic [COORD_W+DIM_W-1:0] p2_nh_q;
  logic [COORD_W-1:0]   p2_qr_q, p2_qc_q, p2_mrem_q;
  logic [2*DIM_W-1:0]   p3_oc_q;
  logic [30:0]          p3_wr_q;
  logic [COORD_W+DIM_W-1:0] p3_nh_q;
  logic [COORD_W-1:0]   p3_qc_q, p3_mrem_q;
  logic [30:0]          p4_ocq_q, p4_wr_q;
  logic [COORD_W+DIM_W-1:0] p4_nh_q;
  logic [COORD_W-1:0]   p4_mrem_q;
  logic [IDX_W-1:0]     p5_pos_q, p6_pos_q;
  logic [OFF_W-1:0]     p6_off_q;
  logic [31:0]          pos_sum;

  assign pos_sum = 32'(p4_ocq_q) + 32'(p4_wr_q) + 32'(p4_nh_q) + 32'(p4_mrem_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= '0;
      b_v_q <= '0;
      p_v_q <= '0;
    end else if (en) begin
      a_v_q <= {a_v_q[DIV_STEPS-2:0], acc};
      b_v_q <= {b_v_q[DIV_STEPS-2:0], a_v_q[L]};
      p_v_q <= {p_v_q[4:0], b_v_q[L]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_m_q[0]   <= div_step(a_m_in, srows_q);
      a_n_q[0]   <= div_step(a_n_in, scols_q);
      a_oor_q[0] <= a_oor_in;
      for (int k = 1; k < DIV_STEPS; k++) begin
        a_m_q[k]   <= div_step(a_m_q[k-1], srows_q);
        a_n_q[k]   <= div_step(a_n_q[k-1], scols_q);
        a_oor_q[k] <= a_oor_q[k-1];
      end

      b_r_q[0]    <= div_step(b_r_in, DIM_W'(grows_q));
      b_c_q[0]    <= div_step(b_c_in, DIM_W'(gcols_q));
      b_mrem_q[0] <= a_m_q[L].rem[COORD_W-1:0];
      b_nrem_q[0] <= a_n_q[L].rem[COORD_W-1:0];
      b_oor_q[0]  <= a_oor_q[L];
      b_hsel_q[0] <= a_m_q[L].quo >= tq_q;
      b_wsel_q[0] <= a_n_q[L].quo >= cq_q;
      for (int k = 1; k < DIV_STEPS; k++) begin
        b_r_q[k]    <= div_step(b_r_q[k-1], DIM_W'(grows_q));
        b_c_q[k]    <= div_step(b_c_q[k-1], DIM_W'(gcols_q));
        b_mrem_q[k] <= b_mrem_q[k-1];
        b_nrem_q[k] <= b_nrem_q[k-1];
        b_oor_q[k]  <= b_oor_q[k-1];
        b_hsel_q[k] <= b_hsel_q[k-1];
        b_wsel_q[k] <= b_wsel_q[k-1];
      end

      // owner, owned-row count and partial super-tile sizes
      p1_o_q.rank <= rank_full[RANK_W-1:0];
      p1_o_q.grow <= rr;
      p1_o_q.gcol <= cr;
      p1_o_q.oor  <= b_oor_q[L];
      p1_o_q.loc  <= !b_oor_q[L] && (rank_full[RANK_W-1:0] == my_rank_q);
      p1_ownm_q   <= {{DIM_W{1'b0}}, nown} * {{DIM_W{1'b0}}, srows_q};
      // last super-tile row may be partial: drop its missing rows
      p1_dsub_q   <= ((rr == nsr_q) && (tr_q != '0)) ? DIM_W'(srows_q - tr_q) : '0;
      p1_wid_q    <= b_wsel_q[L] ? cr_q : scols_q;
      p1_hgt_q    <= b_hsel_q[L] ? tr_q : srows_q;
      p1_qr_q     <= qr;
      p1_qc_q     <= qc;
      p1_mrem_q   <= b_mrem_q[L];
      p1_nrem_q   <= b_nrem_q[L];

      p2_o_q     <= p1_o_q;
      p2_owned_q <= DIM_W'(p1_ownm_q - {{DIM_W{1'b0}}, p1_dsub_q});
      p2_wh_q    <= {{DIM_W{1'b0}}, p1_wid_q} * {{DIM_W{1'b0}}, srows_q};
      p2_nh_q    <= {{DIM_W{1'b0}}, p1_nrem_q} * {{COORD_W{1'b0}}, p1_hgt_q};
      p2_qr_q    <= p1_qr_q;
      p2_qc_q    <= p1_qc_q;
      p2_mrem_q  <= p1_mrem_q;

      p3_o_q    <= p2_o_q;
      p3_oc_q   <= {{DIM_W{1'b0}}, p2_owned_q} * {{DIM_W{1'b0}}, scols_q};
      p3_wr_q   <= 31'(p2_wh_q) * 31'(p2_qr_q);
      p3_nh_q   <= p2_nh_q;
      p3_qc_q   <= p2_qc_q;
      p3_mrem_q <= p2_mrem_q;

      p4_o_q    <= p3_o_q;
      p4_ocq_q  <= 31'(p3_oc_q) * 31'(p3_qc_q);
      p4_wr_q   <= p3_wr_q;
      p4_nh_q   <= p3_nh_q;
      p4_mrem_q <= p3_mrem_q;

      p5_o_q   <= p4_o_q;
      p5_pos_q <= p4_o_q.loc ? pos_sum[IDX_W-1:0] : '0;

      p6_o_q   <= p5_o_q;
      p6_pos_q <= p5_pos_q;
      p6_off_q <= OFF_W'({{(OFF_W-IDX_W){1'b0}}, p5_pos_q} *
                         {{(OFF_W-ELEMS_W){1'b0}}, elems_q});
    end
  end

  assign loc_o.valid            = p_v_q[5];
  assign loc_o.owner_rank       = p6_o_q.rank;
  assign loc_o.owner_grid_row   = p6_o_q.grow;
  assign loc_o.owner_grid_col   = p6_o_q.gcol;
  assign loc_o.is_local         = p6_o_q.loc;
  assign loc_o.local_tile_index = p6_pos_q;
  assign loc_o.element_offset   = p6_off_q;
  assign loc_o.out_of_range     = p6_o_q.oor;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != CS_IDLE) |-> !req_i.ready)
    else $error("item taken while derived config is being rebuilt");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (state_q == CS_ROWS))
    else $error("config write did not restart the derivation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (loc_o.valid && loc_o.is_local) |-> !loc_o.out_of_range)
    else $error("out-of-range tile reported as local");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (loc_o.valid && !loc_o.is_local) |->
      (loc_o.local_tile_index == '0) && (loc_o.element_offset == '0))
    else $error("remote tile has nonzero local position");
`endif

endmodule
